// ===== rtl/content_light_level_stats_macros.svh =====
`ifndef CONTENT_LIGHT_LEVEL_STATS_MACROS_SVH
`define CONTENT_LIGHT_LEVEL_STATS_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge.
`define CLLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge.
`define CLLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/clls_pkg.sv =====
`default_nettype none

package clls_pkg;

   // Pixel count and sample widths.
   localparam int COUNT_BITS  = 26;
   localparam int SAMPLE_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int SUM_BITS    = COUNT_BITS + SAMPLE_BITS;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [STEP_BITS-1:0]  LAST_STEP = STEP_BITS'(SAMPLE_BITS - 1);

   // Controller states.
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } ctrl_stat_type;

   // Take a channel field into the internal sample width.
   function automatic logic [SAMPLE_BITS-1:0] sample_of(input logic [FIELD_BITS-1:0] x);
      logic [SAMPLE_BITS+FIELD_BITS-1:0] wide;
      wide = {{SAMPLE_BITS{1'b0}}, x};
      return wide[SAMPLE_BITS-1:0];
   endfunction

   // Bring an internal sample back to the result field width.
   function automatic logic [FIELD_BITS-1:0] field_of(input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, s};
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/clls_pixel_if.sv =====
`default_nettype none

interface clls_pixel_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic        last_pixel;

   modport source (output valid, output red, output green, output blue,
                   output last_pixel, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/clls_result_if.sv =====
`default_nettype none

interface clls_result_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_cll;
   logic [15:0] mean_level;
   logic        count_overflow;

   modport source (output valid, output max_cll, output mean_level,
                   output count_overflow, input ready);
   modport sink   (input valid, input max_cll, input mean_level,
                   input count_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/clls_ctrl.sv =====
`default_nettype none

module clls_ctrl
   import clls_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   input  wire ctrl_stat_type stat,
   output logic               req_ready,
   output ctrl_cmd_type       cmd
);

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   // State and divide step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state: accumulate until the last pixel, then divide one bit per cycle.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_valid && req_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
            step_in  = '0;
         end
         ST_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // Outputs decoded from the current state.
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/clls_datapath.sv =====
`default_nettype none

module clls_datapath
   import clls_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ctrl_cmd_type    cmd,
   input  wire logic [15:0]     req_red,
   input  wire logic [15:0]     req_green,
   input  wire logic [15:0]     req_blue,
   input  wire logic            rsp_ready,
   output ctrl_stat_type        stat,
   output logic                 rsp_valid,
   output logic [15:0]          rsp_max_cll,
   output logic [15:0]          rsp_mean_level,
   output logic                 rsp_count_overflow
);

   logic [SAMPLE_BITS-1:0] red_s, green_s, blue_s, pix_max;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS:0]    trial, trial_diff;
   logic                   trial_ge;
   logic                   out_valid_ff, out_valid_in;
   logic [FIELD_BITS-1:0]  out_cll_ff, out_cll_in;
   logic [FIELD_BITS-1:0]  out_fall_ff, out_fall_in;
   logic                   out_ovf_ff, out_ovf_in;

   // Largest of the three channels.
   always_comb begin
      red_s   = sample_of(req_red);
      green_s = sample_of(req_green);
      blue_s  = sample_of(req_blue);
      pix_max = red_s;
      if (green_s > pix_max) begin
         pix_max = green_s;
      end
      if (blue_s > pix_max) begin
         pix_max = blue_s;
      end
   end

   // One restoring division step: shift in the next dividend bit and subtract.
   always_comb begin
      trial      = {rem_ff, quo_ff[SAMPLE_BITS-1]};
      trial_ge   = trial >= {1'b0, count_ff};
      trial_diff = trial - {1'b0, count_ff};
   end

   // Frame accumulators and divider registers.
   always_comb begin
      max_in   = max_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.accept) begin
         if (pix_max > max_ff) begin
            max_in = pix_max;
         end
         if (count_ff == COUNT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + {{COUNT_BITS{1'b0}}, pix_max};
         end
      end
      if (cmd.load) begin
         rem_in = sum_ff[SUM_BITS-1:SAMPLE_BITS];
         quo_in = sum_ff[SAMPLE_BITS-1:0];
      end
      if (cmd.step) begin
         rem_in = trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[SAMPLE_BITS-2:0], trial_ge};
      end
      if (cmd.finish) begin
         max_in   = '0;
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Output register: loaded at the end of the division, freed by the sink.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cll_in   = out_cll_ff;
      out_fall_in  = out_fall_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_cll_in   = field_of(max_ff);
         out_fall_in  = field_of(quo_ff);
         out_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cll_ff  <= out_cll_in;
      out_fall_ff <= out_fall_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign stat.out_free      = !out_valid_ff || rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_max_cll        = out_cll_ff;
   assign rsp_mean_level     = out_fall_ff;
   assign rsp_count_overflow = out_ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/content_light_level_stats.sv =====
// After a frame's last pixel beat is taken, its sum is loaded, divided and written
// to the result register. Throughput: one pixel beat per cycle inside a frame;
// after the last pixel the input stalls while a bit-serial divider forms MaxFALL,
// one quotient bit per cycle, and the result register must be free to finish.
// Reset: synchronous, active high; clears the frame accumulators and the result valid flag.
`default_nettype none

module content_light_level_stats
   import clls_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   clls_pixel_if.sink     req_chan,
   clls_result_if.source  rsp_chan
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Frame sequencing.
   clls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_pixel),
      .stat      (stat),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   // Accumulators, divider and result register.
   clls_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_red            (req_chan.red),
      .req_green          (req_chan.green),
      .req_blue           (req_chan.blue),
      .rsp_ready          (rsp_chan.ready),
      .stat               (stat),
      .rsp_valid          (rsp_chan.valid),
      .rsp_max_cll        (rsp_chan.max_cll),
      .rsp_mean_level     (rsp_chan.mean_level),
      .rsp_count_overflow (rsp_chan.count_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/clls_checker.sv =====
`default_nettype none
`include "content_light_level_stats_macros.svh"

module clls_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_max_cll,
   input wire logic [15:0] rsp_mean_level,
   input wire logic        rsp_count_overflow
);

   // A stalled result holds its value.
   `CLLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max_cll) && $stable(rsp_mean_level) && $stable(rsp_count_overflow))

   // The mean of the frame can never exceed its maximum.
   `CLLS_ASSERT_NOW(a_fall_le_cll, clock, reset, rsp_valid, rsp_mean_level <= rsp_max_cll)

   // Input stalls while the divider works on a finished frame.
   `CLLS_ASSERT_NEXT(a_stall_after_last, clock, reset, req_valid && req_ready && req_last, !req_ready)

   // Reset leaves no result pending.
   `CLLS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind content_light_level_stats clls_checker u_clls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_last           (req_chan.last_pixel),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_max_cll        (rsp_chan.max_cll),
   .rsp_mean_level     (rsp_chan.mean_level),
   .rsp_count_overflow (rsp_chan.count_overflow)
);

`default_nettype wire

// ===== verif/frame_stats_checker.sv =====
`timescale 1ns / 1ps

module frame_stats_checker
   import clls_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   clls_pixel_if  pixel_mon,
   clls_result_if level_mon,
   output int     failures,
   output int     frames_pending
);

   typedef struct packed {
      logic [FIELD_BITS-1:0] max_cll;
      logic [FIELD_BITS-1:0] mean_level;
      logic                  count_overflow;
   } light_levels_type;

   // Light levels of finished frames, oldest first, waiting for their result beat.
   light_levels_type expected_levels[$];

   // Running statistics of the frame in progress.
   logic [SAMPLE_BITS-1:0] frame_peak;
   logic [SUM_BITS-1:0]    frame_sum;
   logic [COUNT_BITS-1:0]  frame_pixels;
   logic                   frame_saturated;
   int                     mismatch_count;

   // The brightness of one pixel is the largest of its three channels.
   function automatic logic [SAMPLE_BITS-1:0] brightest_channel(
      input logic [FIELD_BITS-1:0] r,
      input logic [FIELD_BITS-1:0] g,
      input logic [FIELD_BITS-1:0] b);
      logic [SAMPLE_BITS-1:0] peak;
      peak = SAMPLE_BITS'(r);
      if (SAMPLE_BITS'(g) > peak) peak = SAMPLE_BITS'(g);
      if (SAMPLE_BITS'(b) > peak) peak = SAMPLE_BITS'(b);
      return peak;
   endfunction

   task automatic clear_frame();
      frame_peak      = '0;
      frame_sum       = '0;
      frame_pixels    = '0;
      frame_saturated = 1'b0;
   endtask

   // Fold one pixel into the frame; the last pixel closes the frame and yields its levels.
   task automatic accumulate_pixel(
      input logic [FIELD_BITS-1:0] r,
      input logic [FIELD_BITS-1:0] g,
      input logic [FIELD_BITS-1:0] b,
      input logic                  last);
      logic [SAMPLE_BITS-1:0] peak;
      logic [SUM_BITS-1:0]    mean;
      light_levels_type       levels;
      peak = brightest_channel(r, g, b);
      if (peak > frame_peak) frame_peak = peak;

      // Once the count is full, further pixels flag the overflow but are not counted or summed.
      if (frame_pixels == COUNT_MAX) begin
         frame_saturated = 1'b1;
      end else begin
         frame_pixels = frame_pixels + 1'b1;
         frame_sum    = frame_sum + SUM_BITS'(peak);
      end

      if (last) begin
         mean = (frame_pixels != '0) ? frame_sum / SUM_BITS'(frame_pixels) : '0;
         levels.max_cll        = FIELD_BITS'(frame_peak);
         levels.mean_level     = FIELD_BITS'(mean[SAMPLE_BITS-1:0]);
         levels.count_overflow = frame_saturated;
         expected_levels.push_back(levels);
         clear_frame();
      end
   endtask

   // Compare a result beat field by field with the oldest finished frame.
   task automatic check_levels(input light_levels_type got);
      light_levels_type want;
      if (expected_levels.size() == 0) begin
         $error("result beat with no frame finished: max_cll %0d, mean_level %0d, overflow %0d",
                got.max_cll, got.mean_level, got.count_overflow);
         mismatch_count++;
      end else begin
         want = expected_levels.pop_front();
         if (got.max_cll !== want.max_cll) begin
            $error("max_cll: expected %0d, got %0d", want.max_cll, got.max_cll);
            mismatch_count++;
         end
         if (got.mean_level !== want.mean_level) begin
            $error("mean_level: expected %0d, got %0d", want.mean_level, got.mean_level);
            mismatch_count++;
         end
         if (got.count_overflow !== want.count_overflow) begin
            $error("count_overflow: expected %0d, got %0d",
                   want.count_overflow, got.count_overflow);
            mismatch_count++;
         end
      end
   endtask

   // Watch both channels on every rising edge.
   always @(posedge clock) begin
      light_levels_type got;
      if (reset) begin
         clear_frame();
         expected_levels.delete();
         mismatch_count = 0;
      end else begin
         if (level_mon.valid && level_mon.ready) begin
            got.max_cll        = level_mon.max_cll;
            got.mean_level     = level_mon.mean_level;
            got.count_overflow = level_mon.count_overflow;
            check_levels(got);
         end
         if (pixel_mon.valid && pixel_mon.ready) begin
            accumulate_pixel(pixel_mon.red, pixel_mon.green, pixel_mon.blue,
                             pixel_mon.last_pixel);
         end
      end
      failures       <= mismatch_count;
      frames_pending <= expected_levels.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int RANDOM_PIXELS  = 1850;
   localparam int RESULT_LATENCY = 18;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   failures;
   int   frames_pending;
   bit   steady = 1'b0;

   clls_pixel_if  pixel_bus();
   clls_result_if level_bus();

   content_light_level_stats u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_bus),
      .rsp_chan (level_bus)
   );

   frame_stats_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .pixel_mon      (pixel_bus),
      .level_mon      (level_bus),
      .failures       (failures),
      .frames_pending (frames_pending)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Idle cycles before a beat; none at all while a steady stretch runs.
   function automatic int idle_cycles();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // Channel values lean toward the dark and bright ends now and then.
   function automatic logic [15:0] channel_value();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF - 16'($urandom_range(0, 15));
         1: return 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Present one pixel beat at the falling edge and hold it until it is taken.
   task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic last);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pixel_bus.valid      <= 1'b1;
      pixel_bus.red        <= r;
      pixel_bus.green      <= g;
      pixel_bus.blue       <= b;
      pixel_bus.last_pixel <= last;
      @(posedge clock);
      while (pixel_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending until every finished frame has delivered its levels.
   task automatic wait_for_levels();
      pixel_bus.valid <= 1'b0;
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
   endtask

   // Mostly short frames, with an occasional long one.
   task automatic send_random_frame(output int pixels);
      pixels = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
      for (int i = 0; i < pixels; i++) begin
         send_pixel(channel_value(), channel_value(), channel_value(), i == pixels - 1);
      end
   endtask

   // Result side: random stalls before taking each beat.
   initial begin
      int gap;
      level_bus.ready <= 1'b0;
      @(negedge clock);
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            level_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         level_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(level_bus.valid && level_bus.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Pixel stream: directed frames, then random frames, then the verdict.
   initial begin
      int pixels_sent;
      int frame_pixels;
      pixel_bus.valid      <= 1'b0;
      pixel_bus.red        <= '0;
      pixel_bus.green      <= '0;
      pixel_bus.blue       <= '0;
      pixel_bus.last_pixel <= 1'b0;
      pixels_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-pixel frames at black and at full scale.
      send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      // Each channel in turn is the brightest one.
      send_pixel(16'h0100, 16'h0020, 16'h0003, 1'b0);
      send_pixel(16'h0007, 16'h0800, 16'h0030, 1'b0);
      send_pixel(16'h0011, 16'h0022, 16'h9000, 1'b1);
      // The mean is truncated: three over two gives one.
      send_pixel(16'h0001, 16'h0000, 16'h0000, 1'b0);
      send_pixel(16'h0002, 16'h0002, 16'h0000, 1'b1);
      // Alternating bit patterns on every channel.
      send_pixel(16'hAAAA, 16'h5555, 16'h0000, 1'b0);
      send_pixel(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
      send_pixel(16'h5555, 16'h5555, 16'h5555, 1'b0);
      send_pixel(16'h0000, 16'h0000, 16'hAAAA, 1'b1);
      // Full-scale mean, reached through a different channel each pixel.
      send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      // A bright pixel followed by a nearly black last pixel.
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_pixel(16'h0000, 16'h0000, 16'h0001, 1'b1);
      // Channels tied at the top.
      send_pixel(16'h4000, 16'h4000, 16'h3FFF, 1'b1);

      wait_for_levels();

      // Random frames; idling on or off per frame, with an occasional drain.
      while (pixels_sent < RANDOM_PIXELS) begin
         steady = ($urandom_range(0, 3) == 0);
         send_random_frame(frame_pixels);
         pixels_sent += frame_pixels;
         if ($urandom_range(0, 19) == 0) wait_for_levels();
      end

      wait_for_levels();
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      if (failures == 0 && frames_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/clls_pkg.sv
rtl/clls_pixel_if.sv
rtl/clls_result_if.sv
rtl/clls_ctrl.sv
rtl/clls_datapath.sv
rtl/content_light_level_stats.sv
rtl/clls_checker.sv
verif/frame_stats_checker.sv
verif/testbench.sv
